FILE: rtl/i2cmbe_pkg.sv
// shared types, codes and helpers for the i2c master byte engine
`timescale 1ns / 1ps

package i2cmbe_pkg;

   // width of the bus delay counter
   localparam int DELAY_COUNT_BITS = 16;
   localparam int DELAY_REG_BITS   = 16;
   localparam logic [31:0] DELAY_TOP = 32'((64'd1 << DELAY_COUNT_BITS) - 64'd1);

   // command codes carried by the kind field
   typedef enum logic [2:0] {
      KIND_TICK       = 3'd0,
      KIND_START      = 3'd1,
      KIND_STOP       = 3'd2,
      KIND_WRITE      = 3'd3,
      KIND_ADDR_WRITE = 3'd4,
      KIND_READ       = 3'd5
   } kind_type;

   // bus sequencer phases
   typedef enum logic [4:0] {
      PH_IDLE    = 5'd0,
      PH_ST_A    = 5'd1,
      PH_ST_B    = 5'd2,
      PH_SP_A    = 5'd3,
      PH_SP_B    = 5'd4,
      PH_WB_LOW  = 5'd5,
      PH_WB_HIGH = 5'd6,
      PH_WA1     = 5'd7,
      PH_WA2     = 5'd8,
      PH_RD_LOW  = 5'd9,
      PH_RD_HIGH = 5'd10,
      PH_RA1     = 5'd11,
      PH_RA2     = 5'd12
   } phase_type;

   // one result word
   typedef struct packed {
      logic       scl;
      logic       sda_out;
      logic       busy_res;
      logic       done_res;
      logic       acked;
      logic [7:0] read_byte;
      logic       rejected;
   } rsp_word_type;

   // delay reload value: zero counts as one, saturate to the counter range
   function automatic logic [DELAY_COUNT_BITS-1:0] delay_load(
      input logic [DELAY_REG_BITS-1:0] delay);
      logic [31:0] d;
      d = 32'(delay);
      if (d == 32'd0) begin
         d = 32'd1;
      end
      if (d > DELAY_TOP) begin
         d = DELAY_TOP;
      end
      return d[DELAY_COUNT_BITS-1:0];
   endfunction

endpackage

FILE: rtl/i2c_master_byte_engine_top.sv
// i2c master byte engine: command/tick sequencer with registered result words
// each accepted request word gives a registered result word; one request word per cycle
// while req_ready is high; the state register update is the only loop
// a result register plus a skid register; req_ready drops only while the skid register
// holds a word, from the cycle after an accept to a stalled output until rsp_ready drains it
// reset (synchronous, active high): bus idle with scl and sda released, delay of 4 ticks,
// no result words pending
`timescale 1ns / 1ps

module i2c_master_byte_engine_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [2:0]                         req_kind,
   input  logic [7:0]                         req_data_byte,
   input  logic                               req_sda_in,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_scl,
   output logic                               rsp_sda_out,
   output logic                               rsp_busy_res,
   output logic                               rsp_done_res,
   output logic                               rsp_acked,
   output logic [7:0]                         rsp_read_byte,
   output logic                               rsp_rejected,
   input  logic                               csr_wr_en,
   input  logic [i2cmbe_pkg::DELAY_REG_BITS-1:0] csr_wr_data
);
   import i2cmbe_pkg::*;

   // architectural state
   logic [DELAY_REG_BITS-1:0]   delay_ff;
   phase_type                   phase_ff, phase_in;
   kind_type                    cmd_ff, cmd_in;
   logic [3:0]                  bit_index_ff, bit_index_in;
   logic [7:0]                  shift_ff, shift_in;
   logic [DELAY_COUNT_BITS-1:0] wait_ff, wait_in;
   logic                        scl_ff, scl_in;
   logic                        sda_ff, sda_in;
   logic                        ack_ff, ack_in;
   logic [7:0]                  read_hold_ff, read_hold_in;

   // output stage
   logic         out_valid_ff, skid_valid_ff;
   rsp_word_type out_word_ff, skid_word_ff;
   rsp_word_type new_word;

   logic     accept;
   logic     done;
   logic     rej;
   kind_type kind;

   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign kind      = kind_type'(req_kind);

   // next state for one word
   always_comb begin
      logic [DELAY_COUNT_BITS-1:0] wc;
      logic [2:0]                  nxt_idx;
      phase_in     = phase_ff;
      cmd_in       = cmd_ff;
      bit_index_in = bit_index_ff;
      shift_in     = shift_ff;
      wait_in      = wait_ff;
      scl_in       = scl_ff;
      sda_in       = sda_ff;
      ack_in       = ack_ff;
      read_hold_in = read_hold_ff;
      done         = 1'b0;
      rej          = 1'b0;
      wc           = '0;
      nxt_idx      = bit_index_ff[2:0] + 3'd1;

      unique case (kind)
         KIND_TICK: begin
            if (phase_ff != PH_IDLE) begin
               wc      = (wait_ff != '0) ? wait_ff - 1'b1 : '0;
               wait_in = wc;
               if (wc == '0) begin
                  // end of one delay
                  unique case (phase_ff)
                     PH_ST_A: begin
                        sda_in   = 1'b0;
                        phase_in = PH_ST_B;
                     end
                     PH_ST_B: begin
                        scl_in = 1'b0;
                        done   = 1'b1;
                     end
                     PH_SP_A: begin
                        sda_in   = 1'b1;
                        phase_in = PH_SP_B;
                     end
                     PH_SP_B: begin
                        scl_in = 1'b1;
                        done   = 1'b1;
                     end
                     PH_WB_LOW: begin
                        scl_in   = 1'b1;
                        phase_in = PH_WB_HIGH;
                     end
                     PH_WB_HIGH: begin
                        scl_in = 1'b0;
                        if (bit_index_ff < 4'd7) begin
                           bit_index_in = bit_index_ff + 4'd1;
                           sda_in       = shift_ff[~nxt_idx];
                           phase_in     = PH_WB_LOW;
                        end else begin
                           sda_in   = 1'b1;
                           phase_in = PH_WA1;
                        end
                     end
                     PH_WA1: begin
                        scl_in   = 1'b1;
                        phase_in = PH_WA2;
                     end
                     PH_WA2: begin
                        if (req_sda_in) begin
                           ack_in = 1'b0;
                           // address write sends its own stop on nack
                           if (cmd_ff == KIND_ADDR_WRITE) begin
                              scl_in   = 1'b0;
                              sda_in   = 1'b0;
                              phase_in = PH_SP_A;
                           end else begin
                              done = 1'b1;
                           end
                        end else begin
                           ack_in = 1'b1;
                           scl_in = 1'b0;
                           done   = 1'b1;
                        end
                     end
                     PH_RD_LOW: begin
                        scl_in                       = 1'b1;
                        shift_in[~bit_index_ff[2:0]] = req_sda_in;
                        phase_in                     = PH_RD_HIGH;
                     end
                     PH_RD_HIGH: begin
                        scl_in = 1'b0;
                        if (bit_index_ff < 4'd7) begin
                           bit_index_in = bit_index_ff + 4'd1;
                           phase_in     = PH_RD_LOW;
                        end else begin
                           sda_in   = 1'b0;
                           phase_in = PH_RA1;
                        end
                     end
                     PH_RA1: begin
                        scl_in   = 1'b1;
                        phase_in = PH_RA2;
                     end
                     PH_RA2: begin
                        scl_in       = 1'b0;
                        sda_in       = 1'b1;
                        read_hold_in = shift_ff;
                        done         = 1'b1;
                     end
                     default: begin
                        phase_in = PH_IDLE;
                     end
                  endcase
                  if (done) begin
                     phase_in = PH_IDLE;
                  end else begin
                     wait_in = delay_load(delay_ff);
                  end
               end
            end
         end
         KIND_START, KIND_STOP, KIND_WRITE, KIND_ADDR_WRITE, KIND_READ: begin
            if (phase_ff != PH_IDLE) begin
               rej = 1'b1;
            end else begin
               cmd_in       = kind;
               bit_index_in = 4'd0;
               wait_in      = delay_load(delay_ff);
               unique case (kind)
                  KIND_START: begin
                     sda_in   = 1'b1;
                     scl_in   = 1'b1;
                     phase_in = PH_ST_A;
                  end
                  KIND_STOP: begin
                     scl_in   = 1'b0;
                     sda_in   = 1'b0;
                     phase_in = PH_SP_A;
                  end
                  KIND_WRITE, KIND_ADDR_WRITE: begin
                     shift_in = req_data_byte;
                     scl_in   = 1'b0;
                     sda_in   = req_data_byte[7];
                     phase_in = PH_WB_LOW;
                  end
                  default: begin
                     shift_in = 8'd0;
                     phase_in = PH_RD_LOW;
                  end
               endcase
            end
         end
         default: begin
            // unused kinds leave everything as it is
         end
      endcase
   end

   // result word for this request
   always_comb begin
      new_word.scl       = scl_in;
      new_word.sda_out   = sda_in;
      new_word.busy_res  = (phase_in != PH_IDLE);
      new_word.done_res  = done;
      new_word.acked     = ack_in;
      new_word.read_byte = read_hold_in;
      new_word.rejected  = rej;
   end

   // delay register
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= DELAY_REG_BITS'(4);
      end else if (csr_wr_en) begin
         delay_ff <= csr_wr_data;
      end
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         cmd_ff       <= KIND_TICK;
         bit_index_ff <= 4'd0;
         shift_ff     <= 8'd0;
         wait_ff      <= '0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         ack_ff       <= 1'b0;
         read_hold_ff <= 8'd0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         cmd_ff       <= cmd_in;
         bit_index_ff <= bit_index_in;
         shift_ff     <= shift_in;
         wait_ff      <= wait_in;
         scl_ff       <= scl_in;
         sda_ff       <= sda_in;
         ack_ff       <= ack_in;
         read_hold_ff <= read_hold_in;
      end
   end

   // output register and skid register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= accept;
         end
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || rsp_ready) begin
         out_word_ff <= skid_valid_ff ? skid_word_ff : new_word;
      end
      if (out_valid_ff && !rsp_ready && accept) begin
         skid_word_ff <= new_word;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_scl       = out_word_ff.scl;
   assign rsp_sda_out   = out_word_ff.sda_out;
   assign rsp_busy_res  = out_word_ff.busy_res;
   assign rsp_done_res  = out_word_ff.done_res;
   assign rsp_acked     = out_word_ff.acked;
   assign rsp_read_byte = out_word_ff.read_byte;
   assign rsp_rejected  = out_word_ff.rejected;

endmodule

FILE: rtl/i2cmbe_checker.sv
// port-level checks for the i2c master byte engine, bound to the top level
`timescale 1ns / 1ps

module i2cmbe_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic [2:0]                         req_kind,
   input logic [7:0]                         req_data_byte,
   input logic                               req_sda_in,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic                               rsp_scl,
   input logic                               rsp_sda_out,
   input logic                               rsp_busy_res,
   input logic                               rsp_done_res,
   input logic                               rsp_acked,
   input logic [7:0]                         rsp_read_byte,
   input logic                               rsp_rejected,
   input logic                               csr_wr_en,
   input logic [i2cmbe_pkg::DELAY_REG_BITS-1:0] csr_wr_data
);

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_byte) && $stable(rsp_scl))
      else $error("stalled result word changed");

   // reset leaves no result word pending
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word pending after reset");

   // input stalls only when a result word is already waiting
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with empty output");

   // a rejected command means the engine was and stays busy
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rejected |-> rsp_busy_res && !rsp_done_res)
      else $error("reject reported while idle");

   // a finished command returns the engine to idle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_busy_res)
      else $error("done reported while still busy");

endmodule

bind i2c_master_byte_engine_top i2cmbe_checker u_i2cmbe_checker (.*);
